// ===== design/tpl_pkg.sv =====
// ---------------------------------------------------------------------------
// tpl_pkg: shared types and constants for the track predictor
// Word formats, command and lifecycle codes, controller states, helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package tpl_pkg;

   localparam int CovWidthDefault   = 40;
   localparam int CountWidthDefault = 8;
   localparam int CovWidthMax       = 48;
   localparam int CountWidthMax     = 16;
   localparam int RootSteps         = 32;

   localparam logic [31:0] InitCovReset   = 32'd65536;
   localparam logic [31:0] ProcVarReset   = 32'd65536;
   localparam logic [7:0]  MaxCoastReset  = 8'd5;

   localparam logic [1:0] CMD_CREATE   = 2'd0;
   localparam logic [1:0] CMD_DETECT   = 2'd1;
   localparam logic [1:0] CMD_NODETECT = 2'd2;
   localparam logic [1:0] CMD_SPARE    = 2'd3;

   localparam logic [1:0] CSR_INIT_COV  = 2'd0;
   localparam logic [1:0] CSR_PROC_VAR  = 2'd1;
   localparam logic [1:0] CSR_MAX_COAST = 2'd2;

   typedef enum logic [1:0] {
      LC_INIT   = 2'd0,
      LC_ACTIVE = 2'd1,
      LC_COAST  = 2'd2,
      LC_TERM   = 2'd3
   } lc_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_CREATE,
      ST_PRED,
      ST_SEED,
      ST_PRED2,
      ST_LIFE,
      ST_DIFF,
      ST_SQX,
      ST_SQY,
      ST_RINIT,
      ST_ROOT,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [23:0] x_meas;
      logic signed [23:0] y_meas;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         track_status;
      logic signed [31:0] est_x;
      logic signed [31:0] est_y;
      logic signed [31:0] est_vx;
      logic signed [31:0] est_vy;
      logic [7:0]         coast_frames;
      logic [31:0]        meas_distance;
      logic [39:0]        pos_variance_x;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic create;
      logic predict;
      logic seed;
      logic life_upd;
      logic diff;
      logic sq_x;
      logic sq_y;
      logic root_init;
      logic root_step;
      logic out_load;
   } tpl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] command;
      lc_type     lifecycle;
      logic       root_last;
   } tpl_stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/tpl_ctrl.sv =====
// ---------------------------------------------------------------------------
// tpl_ctrl: sequencer for the track predictor
// Walks one word through create / predict / lifecycle / distance steps.
// ---------------------------------------------------------------------------
`default_nettype none

module tpl_ctrl
   import tpl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   input  wire tpl_stat_type stat,
   output tpl_cmd_type       ctl
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;
   logic           frame_live;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign frame_live = (stat.command == CMD_DETECT || stat.command == CMD_NODETECT)
                       && stat.lifecycle != LC_TERM;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (stat.command == CMD_CREATE) begin
               state_in = ST_CREATE;
            end else if (frame_live) begin
               if (stat.lifecycle != LC_INIT)        state_in = ST_PRED;
               else if (stat.command == CMD_DETECT)  state_in = ST_SEED;
               else                                  state_in = ST_LIFE;
            end else if (stat.command == CMD_DETECT) begin
               state_in = ST_DIFF;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_CREATE: state_in = ST_OUT;
         ST_PRED:   state_in = ST_LIFE;
         ST_SEED:   state_in = ST_PRED2;
         ST_PRED2:  state_in = ST_LIFE;
         ST_LIFE:   state_in = (stat.command == CMD_DETECT) ? ST_DIFF : ST_OUT;
         ST_DIFF:   state_in = ST_SQX;
         ST_SQX:    state_in = ST_SQY;
         ST_SQY:    state_in = ST_RINIT;
         ST_RINIT:  state_in = ST_ROOT;
         ST_ROOT:   if (stat.root_last) state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl           = '0;
      ctl.load      = (state_ff == ST_IDLE) && req_valid;
      ctl.create    = (state_ff == ST_CREATE);
      ctl.predict   = (state_ff == ST_PRED) || (state_ff == ST_PRED2);
      ctl.seed      = (state_ff == ST_SEED);
      ctl.life_upd  = (state_ff == ST_LIFE);
      ctl.diff      = (state_ff == ST_DIFF);
      ctl.sq_x      = (state_ff == ST_SQX);
      ctl.sq_y      = (state_ff == ST_SQY);
      ctl.root_init = (state_ff == ST_RINIT);
      ctl.root_step = (state_ff == ST_ROOT);
      ctl.out_load  = (state_ff == ST_OUT) && out_free;
      req_stall     = (state_ff != ST_IDLE);
      rsp_valid     = rsp_valid_ff;
      rsp_valid_in  = ctl.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/tpl_dp.sv =====
// ---------------------------------------------------------------------------
// tpl_dp: datapath for the track predictor
// State vector, covariance, lifecycle, distance multiplier and square root.
// ---------------------------------------------------------------------------
`default_nettype none

module tpl_dp
   import tpl_pkg::*;
#(
   parameter int COV_WIDTH   = CovWidthDefault,
   parameter int COUNT_WIDTH = CountWidthDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_write,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data,
   input  wire req_word_type req_data,
   input  wire tpl_cmd_type  ctl,
   output tpl_stat_type      stat,
   output rsp_word_type      rsp_data
);

   localparam int SumWidth     = COV_WIDTH + 3;
   localparam int RootCntWidth = $clog2(RootSteps);

   logic [31:0] init_cov_ff, proc_var_ff;
   logic [7:0]  max_coast_ff;

   req_word_type req_ff;
   lc_type       life_ff, life_in;
   logic [COUNT_WIDTH-1:0] coast_ff, coast_in;

   logic signed [31:0] x_ff, y_ff, vx_ff, vy_ff;
   logic [COV_WIDTH-1:0] p_ff [4][4];
   logic [COV_WIDTH-1:0] p_in [4][4];
   logic [COV_WIDTH-1:0] d4_ff, d5_ff;
   logic [COV_WIDTH-1:0] pv [6][6];

   logic [31:0] ax_ff, ay_ff;
   logic [63:0] sx_ff, sy_ff, prod;
   logic [63:0] rem_ff, res_ff, bit_ff, trial;
   logic        ovf_ff;
   logic [RootCntWidth-1:0] cnt_ff;
   logic [64:0] sq_sum;

   rsp_word_type rsp_ff;

   logic signed [32:0] xm_ext, ym_ext, dx, dy;
   logic [32:0]        adx, ady;
   logic [CountWidthMax-1:0] coast_wide;
   logic [CovWidthMax-1:0]   var_wide;

   assign xm_ext = 33'(req_ff.x_meas);
   assign ym_ext = 33'(req_ff.y_meas);
   assign dx     = xm_ext - 33'(x_ff);
   assign dy     = ym_ext - 33'(y_ff);
   assign adx    = dx[32] ? 33'(-dx) : 33'(dx);
   assign ady    = dy[32] ? 33'(-dy) : 33'(dy);

   // 6x6 view; rows/cols 4,5 only carry their diagonal
   always_comb begin
      for (int r = 0; r < 6; r++) begin
         for (int c = 0; c < 6; c++) begin
            pv[r][c] = '0;
         end
      end
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            pv[r][c] = p_ff[r][c];
         end
      end
      pv[4][4] = d4_ff;
      pv[5][5] = d5_ff;
   end

   // P = A P A' + Q, A row i sums entries i and i+2
   always_comb begin
      logic [SumWidth-1:0] s;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            s = SumWidth'(pv[i][j]) + SumWidth'(pv[i][j+2])
              + SumWidth'(pv[i+2][j]) + SumWidth'(pv[i+2][j+2])
              + ((i == j) ? SumWidth'(proc_var_ff) : SumWidth'(0));
            p_in[i][j] = (s[SumWidth-1:COV_WIDTH] != '0) ? '1 : s[COV_WIDTH-1:0];
         end
      end
   end

   always_comb begin
      logic [COUNT_WIDTH-1:0] c;
      lc_type                 l;
      c = coast_ff;
      l = life_ff;
      if (req_ff.command == CMD_NODETECT) begin
         if (life_ff == LC_INIT) begin
            l = LC_TERM;
         end else begin
            l = LC_COAST;
            if (coast_ff != '1) c = coast_ff + 1'b1;
         end
      end else begin
         l = LC_ACTIVE;
         c = '0;
      end
      if (CountWidthMax'(c) > CountWidthMax'(max_coast_ff)) l = LC_TERM;
      coast_in = c;
      life_in  = l;
   end

   assign prod   = 64'(ctl.sq_x ? ax_ff : ay_ff) * 64'(ctl.sq_x ? ax_ff : ay_ff);
   assign sq_sum = 65'(sx_ff) + 65'(sy_ff);
   assign trial  = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_cov_ff  <= InitCovReset;
         proc_var_ff  <= ProcVarReset;
         max_coast_ff <= MaxCoastReset;
         life_ff      <= LC_TERM;
         coast_ff     <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         vx_ff        <= '0;
         vy_ff        <= '0;
         d4_ff        <= '0;
         d5_ff        <= '0;
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               p_ff[r][c] <= '0;
            end
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_INIT_COV:  init_cov_ff  <= csr_data;
               CSR_PROC_VAR:  proc_var_ff  <= csr_data;
               CSR_MAX_COAST: max_coast_ff <= csr_data[7:0];
               default: ;
            endcase
         end
         if (ctl.create) begin
            x_ff     <= 32'(req_ff.x_meas);
            y_ff     <= 32'(req_ff.y_meas);
            vx_ff    <= '0;
            vy_ff    <= '0;
            d4_ff    <= COV_WIDTH'(init_cov_ff);
            d5_ff    <= COV_WIDTH'(init_cov_ff);
            for (int r = 0; r < 4; r++) begin
               for (int c = 0; c < 4; c++) begin
                  p_ff[r][c] <= (r == c) ? COV_WIDTH'(init_cov_ff) : '0;
               end
            end
            life_ff  <= LC_INIT;
            coast_ff <= '0;
         end
         if (ctl.predict) begin
            x_ff  <= sat32(33'(x_ff) + 33'(vx_ff));
            y_ff  <= sat32(33'(y_ff) + 33'(vy_ff));
            p_ff  <= p_in;
            d4_ff <= COV_WIDTH'(proc_var_ff);
            d5_ff <= COV_WIDTH'(proc_var_ff);
         end
         if (ctl.seed) begin
            vx_ff <= sat32(dx);
            vy_ff <= sat32(dy);
         end
         if (ctl.life_upd) begin
            life_ff  <= life_in;
            coast_ff <= coast_in;
         end
      end
   end

   assign coast_wide = CountWidthMax'(coast_ff);
   assign var_wide   = CovWidthMax'(p_ff[0][0]);

   function automatic rsp_word_type rsp_next();
      rsp_word_type w;
      w.track_status   = life_ff;
      w.est_x          = x_ff;
      w.est_y          = y_ff;
      w.est_vx         = vx_ff;
      w.est_vy         = vy_ff;
      w.coast_frames   = coast_wide[7:0];
      w.meas_distance  = (req_ff.command != CMD_DETECT) ? 32'd0 :
                         (ovf_ff ? 32'hFFFF_FFFF : res_ff[31:0]);
      w.pos_variance_x = (var_wide[CovWidthMax-1:40] != '0) ? '1 : var_wide[39:0];
      return w;
   endfunction

   // payload and distance registers, no reset needed
   always_ff @(posedge clock) begin
      if (ctl.load) req_ff <= req_data;
      if (ctl.diff) begin
         ax_ff <= adx[31:0];
         ay_ff <= ady[31:0];
      end
      if (ctl.sq_x) sx_ff <= prod;
      if (ctl.sq_y) sy_ff <= prod;
      if (ctl.root_init) begin
         ovf_ff <= sq_sum[64];
         rem_ff <= sq_sum[63:0];
         res_ff <= '0;
         bit_ff <= 64'd1 << 62;
         cnt_ff <= '0;
      end
      if (ctl.root_step) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (ctl.out_load) rsp_ff <= rsp_next();
   end

   assign stat.command   = req_ff.command;
   assign stat.lifecycle = life_ff;
   assign stat.root_last = (cnt_ff == RootCntWidth'(RootSteps - 1));
   assign rsp_data       = rsp_ff;

endmodule

`default_nettype wire

// ===== design/track_predict_lifecycle.sv =====
// ---------------------------------------------------------------------------
// track_predict_lifecycle: single-track constant-velocity predictor
// Create, predict (X=AX, P=APA'+Q), lifecycle and detection distance.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake             | word
//  req_     | in  | req_valid / req_stall | req_word_type (command, x/y meas)
//  rsp_     | out | rsp_valid / rsp_stall | rsp_word_type (status, estimate,...)
//  csr_     | in  | csr_write             | csr_index, csr_data (32 bit)
//
//  One word in flight: accept, then decide, create or predict/seed/lifecycle
//  steps and output load, which makes the result word.
//  A frame with detection adds the distance steps: difference,
//  two squares on one 32x32 multiplier, root setup, 32-step bit-pair root.
//  The longest path is a first detection in init; the controller goes
//  back to idle after the output load before the next accept.
//  Reset is synchronous; track comes up terminated, registers at defaults.
//  rsp_stall holds the result word; the next word is taken while it waits.
// ---------------------------------------------------------------------------
`default_nettype none

module track_predict_lifecycle
   import tpl_pkg::*;
#(
   parameter int COV_WIDTH   = CovWidthDefault,
   parameter int COUNT_WIDTH = CountWidthDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data,
   input  wire logic         csr_write,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   tpl_cmd_type  ctl;
   tpl_stat_type stat;

   // sequencer
   tpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   // filter state, lifecycle and distance engine
   tpl_dp #(
      .COV_WIDTH   (COV_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

   // one word at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while a word is in flight");

   // datapath commands never overlap
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.create, ctl.predict, ctl.seed, ctl.life_upd, ctl.diff,
                ctl.sq_x, ctl.sq_y, ctl.root_init, ctl.root_step, ctl.out_load}))
      else $error("overlapping datapath commands");

   // create always leaves the track in init
   a_create_init: assert property (@(posedge clock) disable iff (reset)
      ctl.create |=> stat.lifecycle == LC_INIT)
      else $error("create did not enter init");

   // result loads once per word and raises valid
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |=> rsp_valid && !ctl.out_load)
      else $error("result load without valid");

endmodule

`default_nettype wire

// ===== sim/tb_track_predict_lifecycle.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_track_predict_lifecycle: self-checking bench for the track predictor
// Drives create/frame words, predicts every result word in-bench and checks
// each field; walks the lifecycle under several register settings and idling.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_track_predict_lifecycle
   import tpl_pkg::*;
;

   localparam logic [63:0] CovSat   = (64'd1 << 40) - 1;
   localparam int          CycleCap = 3_000_000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_write = 1'b0;
   logic [1:0]   csr_index = CSR_INIT_COV;
   logic [31:0]  csr_data = '0;

   track_predict_lifecycle u_top (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write, .csr_index, .csr_data
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of the block's state and registers
   logic [31:0]        m_init_cov, m_proc_var;
   logic [7:0]         m_max_coast;
   logic signed [31:0] m_sv [6];
   logic [63:0]        m_cov [36];
   lc_type             m_life;
   logic [7:0]         m_coast;

   rsp_word_type expected_q [$];
   int  errors = 0;
   int  sent = 0;
   int  checked = 0;
   int  cycles = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_rsp = 1'b0;

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // X = AX, P = APA' + Q, saturating
   task automatic advance_track();
      logic [63:0]        np [36];
      logic signed [31:0] nx [6];
      logic [63:0]        s;
      int ai, bi, aj, bj;
      for (int i = 0; i < 4; i++)
         nx[i] = clamp32(64'(m_sv[i]) + 64'(m_sv[i + 2]));
      nx[4] = 0;
      nx[5] = 0;
      for (int i = 0; i < 6; i++) m_sv[i] = nx[i];
      for (int i = 0; i < 6; i++) begin
         for (int j = 0; j < 6; j++) begin
            s = 0;
            if (i < 4 && j < 4) begin
               ai = i; bi = i + 2; aj = j; bj = j + 2;
               s = m_cov[ai*6+aj] + m_cov[ai*6+bj] + m_cov[bi*6+aj] + m_cov[bi*6+bj];
            end
            if (i == j) s += m_proc_var;
            np[i*6+j] = (s > CovSat) ? CovSat : s;
         end
      end
      for (int i = 0; i < 36; i++) m_cov[i] = np[i];
   endtask

   function automatic logic [31:0] int_root(input logic [63:0] v);
      logic [63:0] res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits >>= 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v -= res + bits;
            res = (res >> 1) + bits;
         end else begin
            res >>= 1;
         end
         bits >>= 2;
      end
      return res[31:0];
   endfunction

   function automatic logic [31:0] range_to(input logic signed [23:0] xm,
                                            input logic signed [23:0] ym);
      logic signed [63:0] dx, dy;
      logic [63:0] sx, sy, sum;
      dx = 64'(xm) - 64'(m_sv[0]);
      dy = 64'(ym) - 64'(m_sv[1]);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sx = dx * dx;
      sy = dy * dy;
      sum = sx + sy;
      if (sum < sx) return 32'hFFFF_FFFF;
      return int_root(sum);
   endfunction

   function automatic void reset_track_model();
      m_init_cov = InitCovReset;
      m_proc_var = ProcVarReset;
      m_max_coast = MaxCoastReset;
      for (int i = 0; i < 6; i++) m_sv[i] = 0;
      for (int i = 0; i < 36; i++) m_cov[i] = 0;
      m_life = LC_TERM;
      m_coast = 0;
   endfunction

   task automatic track_step(input req_word_type w, output rsp_word_type r);
      r = '0;
      if (w.command == CMD_CREATE) begin
         m_sv[0] = 32'(w.x_meas);
         m_sv[1] = 32'(w.y_meas);
         for (int i = 2; i < 6; i++) m_sv[i] = 0;
         for (int i = 0; i < 36; i++) m_cov[i] = (i % 7 == 0) ? 64'(m_init_cov) : 0;
         m_life = LC_INIT;
         m_coast = 0;
      end else if ((w.command == CMD_DETECT || w.command == CMD_NODETECT)
                   && m_life != LC_TERM) begin
         if (m_life != LC_INIT) advance_track();
         if (w.command == CMD_NODETECT) begin
            if (m_life == LC_INIT) begin
               m_life = LC_TERM;
            end else begin
               m_life = LC_COAST;
               if (m_coast != 8'hFF) m_coast++;
            end
         end else begin
            if (m_life == LC_INIT) begin
               m_sv[2] = clamp32(64'(w.x_meas) - 64'(m_sv[0]));
               m_sv[3] = clamp32(64'(w.y_meas) - 64'(m_sv[1]));
               advance_track();
            end
            m_life = LC_ACTIVE;
            m_coast = 0;
         end
         if (m_coast > m_max_coast) m_life = LC_TERM;
      end
      if (w.command == CMD_DETECT) r.meas_distance = range_to(w.x_meas, w.y_meas);
      r.track_status = m_life;
      r.est_x = m_sv[0];
      r.est_y = m_sv[1];
      r.est_vx = m_sv[2];
      r.est_vy = m_sv[3];
      r.coast_frames = m_coast;
      r.pos_variance_x = m_cov[0][39:0];
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("mismatch word %0d %s: got %0h want %0h", checked, what, got, want);
   endtask

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report("unexpected word", 64'(rsp_data.track_status), 64'd0);
         end else begin
            automatic rsp_word_type e = expected_q.pop_front();
            if (rsp_data.track_status !== e.track_status)
               report("track_status", 64'(rsp_data.track_status), 64'(e.track_status));
            if (rsp_data.est_x !== e.est_x)
               report("est_x", 64'(rsp_data.est_x), 64'(e.est_x));
            if (rsp_data.est_y !== e.est_y)
               report("est_y", 64'(rsp_data.est_y), 64'(e.est_y));
            if (rsp_data.est_vx !== e.est_vx)
               report("est_vx", 64'(rsp_data.est_vx), 64'(e.est_vx));
            if (rsp_data.est_vy !== e.est_vy)
               report("est_vy", 64'(rsp_data.est_vy), 64'(e.est_vy));
            if (rsp_data.coast_frames !== e.coast_frames)
               report("coast_frames", 64'(rsp_data.coast_frames), 64'(e.coast_frames));
            if (rsp_data.meas_distance !== e.meas_distance)
               report("meas_distance", 64'(rsp_data.meas_distance), 64'(e.meas_distance));
            if (rsp_data.pos_variance_x !== e.pos_variance_x)
               report("pos_variance_x", 64'(rsp_data.pos_variance_x),
                      64'(e.pos_variance_x));
         end
         checked <= checked + 1;
      end
   end

   // receiver stall, changed on the falling edge
   always @(negedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (cycles > CycleCap) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------- stimulus helpers ----------------
   task automatic send_word(input req_word_type w);
      rsp_word_type r;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      track_step(w, r);
      expected_q.insert(expected_q.size(), r);
      sent++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send(input logic [1:0] c, input int x, input int y);
      req_word_type w;
      w.command = c;
      w.x_meas = x[23:0];
      w.y_meas = y[23:0];
      send_word(w);
   endtask

   task automatic drain();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // registers only written once the block has gone quiet
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      drain();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_INIT_COV: m_init_cov = val;
         CSR_PROC_VAR: m_proc_var = val;
         default:      m_max_coast = val[7:0];
      endcase
   endtask

   function automatic int rand_coord();
      case ($urandom_range(5))
         0: return 32'sh7FFFFF;
         1: return -32'sh800000;
         2: return $urandom_range(4095) - 2048;
         default: return $signed($urandom) >>> 8;
      endcase
   endfunction

   // a track life: create, detections and gaps, with occasional re-creates, spare and stray words
   task automatic send_track(input int frames);
      int x, y, vx, vy;
      x = rand_coord();
      y = rand_coord();
      vx = $urandom_range(255) - 128;
      vy = $urandom_range(255) - 128;
      send(CMD_CREATE, x, y);
      for (int f = 0; f < frames; f++) begin
         x += vx;
         y += vy;
         case ($urandom_range(19))
            0: send(CMD_CREATE, rand_coord(), rand_coord());
            1: send(CMD_SPARE, rand_coord(), rand_coord());
            2, 3, 4, 5, 6: send(CMD_NODETECT, $urandom, $urandom);
            7: send(CMD_DETECT, rand_coord(), rand_coord());
            default: send(CMD_DETECT, x + $urandom_range(63) - 32, y + $urandom_range(63) - 32);
         endcase
      end
   endtask

   // ---------------- tests ----------------
   task automatic test_directed();
      send(CMD_DETECT, 5, 5);              // terminated after reset: held state
      send(CMD_NODETECT, 0, 0);
      send(CMD_CREATE, 100, -200);
      send(CMD_NODETECT, 0, 0);            // no detection in init: terminates
      send(CMD_CREATE, 32'sh7FFFFF, -32'sh800000);
      send(CMD_DETECT, -32'sh800000, 32'sh7FFFFF);   // first detection, big seed
      for (int i = 0; i < 7; i++) send(CMD_NODETECT, 0, 0);   // coast out
      send(CMD_DETECT, 1, 1);
      send(CMD_SPARE, 32'sh7FFFFF, -1);    // unused command
      send(CMD_CREATE, 0, 0);
      send(CMD_DETECT, 256, 256);
      send(CMD_DETECT, 512, 512);
      send(CMD_SPARE, 0, 0);
      send(CMD_NODETECT, 0, 0);
      send(CMD_DETECT, -32'sh800000, -32'sh800000);
      send(CMD_CREATE, -1, -1);            // create from active
   endtask

   task automatic test_registers();
      write_reg(CSR_INIT_COV, 32'hFFFF_FFFF);
      write_reg(CSR_PROC_VAR, 32'hFFFF_FFFF);
      write_reg(CSR_MAX_COAST, 32'd254);
      send(CMD_CREATE, 10, 10);
      send(CMD_DETECT, 20, 30);
      for (int i = 0; i < 40; i++) send(CMD_NODETECT, 0, 0);   // covariance saturates
      write_reg(CSR_INIT_COV, 0);
      write_reg(CSR_PROC_VAR, 0);
      write_reg(CSR_MAX_COAST, 0);
      send_track(12);
   endtask

   task automatic test_long_coast();
      // coast count saturates when termination never comes
      write_reg(CSR_MAX_COAST, 32'hFF);
      send(CMD_CREATE, 3, 4);
      send(CMD_DETECT, 7, 9);
      for (int i = 0; i < 260; i++) send(CMD_NODETECT, 0, 0);
      send(CMD_DETECT, 0, 0);
      write_reg(CSR_MAX_COAST, 32'(MaxCoastReset));
   endtask

   task automatic test_random(input int words, input int idle, input int stall);
      int start;
      send_idle_pct = idle;
      stall_pct = stall;
      write_reg(CSR_PROC_VAR, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 18));
      write_reg(CSR_INIT_COV, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 18));
      write_reg(CSR_MAX_COAST, $urandom_range(12));
      start = sent;
      while (sent - start < words) begin
         if ($urandom_range(9) == 0) send(2'($urandom), $urandom, $urandom);
         else send_track($urandom_range(30, 2));
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_backpressure();
      // hold the result side while words keep coming, then let it drain
      fork
         begin
            hold_rsp = 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         send_track(10);
      join
      drain();
      send(CMD_CREATE, 1, 2);
   endtask

   initial begin
      reset_track_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_registers();
      test_long_coast();
      test_random(340, 0, 0);
      test_random(340, 64, 0);
      test_random(340, 0, 64);
      test_random(340, 19, 19);
      test_backpressure();
      drain();

      $display("covered create, detection, coasting and termination over %0d words,",
               sent);
      $display("%0d results checked across register extremes and idle mixes", checked);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
